// ----- hdl/luhn_pkg.sv -----
`default_nettype none

package luhn_pkg;

	localparam int CARD_W      = 63;
	localparam int COUNT_W     = 5;
	localparam int VERDICT_W   = 2;
	localparam int NUM_DIGITS  = 19;
	localparam int BCD_W       = 4 * NUM_DIGITS;
	localparam int SHIFT_W     = 64;
	localparam int BITS_PER_CYC = 4;
	localparam int CONV_CYCLES = SHIFT_W / BITS_PER_CYC;

	localparam logic [COUNT_W-1:0] MIN_DIGITS = 5'd13;
	localparam logic [COUNT_W-1:0] MAX_DIGITS = 5'd16;

	localparam logic [VERDICT_W-1:0] VERDICT_INVALID    = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_AMEX       = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_MASTERCARD = 2'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_VISA       = 2'd3;

	// Contribution of one digit to the Luhn sum; doubled digits fold to one digit.
	function automatic logic [3:0] luhn_term(input logic [3:0] d, input logic odd);
		logic [4:0] dbl;
		dbl = {d, 1'b0};
		if (!odd)
			return d;
		else if (d < 4'd5)
			return dbl[3:0];
		else
			return 4'(dbl - 5'd9);
	endfunction

	// Brand from the two leading digits.
	function automatic logic [VERDICT_W-1:0] classify(input logic [3:0] hi, input logic [3:0] lo);
		logic [6:0] lead;
		lead = 7'(hi) * 7'd10 + 7'(lo);
		if (lead == 7'd34 || lead == 7'd37)
			return VERDICT_AMEX;
		else if ((lead >= 7'd51 && lead <= 7'd55) || lead == 7'd22)
			return VERDICT_MASTERCARD;
		else if (hi == 4'd4)
			return VERDICT_VISA;
		else
			return VERDICT_INVALID;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/luhn_card_number_check.sv -----
`default_nettype none

// Channel   Ports                         Handshake
// -------   ---------------------------   ----------------------------------
// item in   card_number                   taken when start=1 and busy=0
// result    verdict, digit_count          shown for one cycle with done=1
//
// An item goes from the accepting edge through binary-to-BCD conversion
// (4 shift/adjust steps per cycle on one shared shifter), then a digit scan
// (one digit per cycle through one adder); the last scan edge raises done and
// also loads the result registers. busy stays high from the accepting edge
// until done; a new item may be started in the cycle that done is shown, but
// not before it.
// arst_n clears the sequencer and the done strobe; payload registers hold junk.
// The receiver cannot stall: every result is taken in its done cycle.

module luhn_card_number_check (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [luhn_pkg::CARD_W-1:0]       card_number,
	output logic                                   done,
	output logic [luhn_pkg::VERDICT_W-1:0]         verdict,
	output logic [luhn_pkg::COUNT_W-1:0]           digit_count
);
	import luhn_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0]         state_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [SHIFT_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [3:0]         sum_q;
	logic [3:0]         prev_q;
	logic [3:0]         hi_q;
	logic [3:0]         lo_q;
	logic [COUNT_W-1:0] top_q;
	logic               found_q;
	logic               done_q;
	logic [VERDICT_W-1:0] verdict_q;
	logic [COUNT_W-1:0] count_q;

	logic [SHIFT_W-1:0] bin_nx;
	logic [BCD_W-1:0]   bcd_nx;

	logic [3:0]         dig;
	logic [3:0]         term;
	logic [4:0]         sum_wide;
	logic [3:0]         sum_nx;
	logic               hit;
	logic [3:0]         hi_nx;
	logic [3:0]         lo_nx;
	logic [COUNT_W-1:0] top_nx;
	logic               found_nx;
	logic [COUNT_W-1:0] count_nx;
	logic               len_ok;
	logic               accept;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// Shift-and-add-3 conversion: several bit steps per cycle, every digit
	// adjusted independently before each shift.
	always_comb begin
		logic [BCD_W-1:0]   b;
		logic [SHIFT_W-1:0] v;
		b = bcd_q;
		v = bin_q;
		for (int s = 0; s < BITS_PER_CYC; s++) begin
			for (int k = 0; k < NUM_DIGITS; k++) begin
				if (b[4*k +: 4] >= 4'd5)
					b[4*k +: 4] = b[4*k +: 4] + 4'd3;
			end
			b = {b[BCD_W-2:0], v[SHIFT_W-1]};
			v = {v[SHIFT_W-2:0], 1'b0};
		end
		bcd_nx = b;
		bin_nx = v;
	end

	// Scan: take the low digit, fold it into the running sum mod 10, and
	// remember the highest nonzero digit with the one below it.
	always_comb begin
		dig      = bcd_q[3:0];
		term     = luhn_term(dig, cnt_q[0]);
		sum_wide = 5'(sum_q) + 5'(term);
		sum_nx   = (sum_wide >= 5'd10) ? 4'(sum_wide - 5'd10) : sum_wide[3:0];
		hit      = (dig != 4'd0);
		hi_nx    = hit ? dig    : hi_q;
		lo_nx    = hit ? prev_q : lo_q;
		top_nx   = hit ? cnt_q  : top_q;
		found_nx = found_q || hit;
		count_nx = found_nx ? top_nx + 5'd1 : '0;
		len_ok   = (count_nx >= MIN_DIGITS) && (count_nx <= MAX_DIGITS);
	end

	// Sequencer and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
						cnt_q   <= '0;
					end
				end
				ST_CONV: begin
					if (cnt_q == COUNT_W'(CONV_CYCLES - 1)) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_SCAN: begin
					if (cnt_q == COUNT_W'(NUM_DIGITS - 1)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: the shifter and the scan registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					bin_q <= {1'b0, card_number};
					bcd_q <= '0;
				end
				sum_q   <= '0;
				prev_q  <= '0;
				hi_q    <= '0;
				lo_q    <= '0;
				top_q   <= '0;
				found_q <= 1'b0;
			end
			ST_CONV: begin
				bin_q <= bin_nx;
				bcd_q <= bcd_nx;
			end
			ST_SCAN: begin
				bcd_q   <= {4'd0, bcd_q[BCD_W-1:4]};
				sum_q   <= sum_nx;
				prev_q  <= dig;
				hi_q    <= hi_nx;
				lo_q    <= lo_nx;
				top_q   <= top_nx;
				found_q <= found_nx;
				if (cnt_q == COUNT_W'(NUM_DIGITS - 1)) begin
					count_q   <= count_nx;
					verdict_q <= (len_ok && sum_nx == 4'd0) ? classify(hi_nx, lo_nx)
					                                       : VERDICT_INVALID;
				end
			end
			default: begin
				bin_q <= bin_q;
			end
		endcase
	end

	assign done        = done_q;
	assign verdict     = verdict_q;
	assign digit_count = count_q;

	// A result only follows the last scan cycle.
	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_SCAN)
		else $error("done without a finished scan");

	// An accepted item makes the block busy as of the accepting edge.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("item accepted but block not busy");

	// The block is free again in the cycle that shows the result.
	a_idle_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while showing result");

	// A brand is only reported for a legal length.
	a_brand_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && verdict != VERDICT_INVALID) |->
			(digit_count >= MIN_DIGITS && digit_count <= MAX_DIGITS))
		else $error("brand reported for illegal length");

endmodule

`default_nettype wire
